FILE: sv/tpmt_pkg.sv
// Package for the timed pending match table.
// Holds operation and outcome codes, flag bit positions and the table entry type.
// No dependencies.
`default_nettype none

package tpmt_pkg;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_SERVER  = 2'd1;
  localparam logic [1:0] MODE_RESOLVE = 2'd2;

  localparam logic [1:0] OUT_NONE  = 2'd0;
  localparam logic [1:0] OUT_HIT   = 2'd1;
  localparam logic [1:0] OUT_SHOWN = 2'd2;

  localparam int FLAG_CRIT  = 0;
  localparam int FLAG_READY = 1;
  localparam int FLAG_SHOWN = 2;

  localparam logic [30:0] HOLD_RESET = 31'd2500;

  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] object_id;
    logic [30:0] loc_amount;
    logic [31:0] expiry;
    logic [30:0] srv_amount;
    logic [2:0]  flags;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/timed_pending_match_table.sv
// Timed pending match table: ring of pending records held in one synchronous memory.
// Uses tpmt_pkg (codes, flag positions, entry_t).
//
// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_stall    mode, now_ms, object_id, mob_handle, amount, critical
// out_      out  out_valid / out_stall  outcome, shown_amount, shown_critical
// cfg_      in   cfg_wr_en              cfg_wr_data (hold time, ms)
//
// Add: the entry is written in the accepting cycle and the word goes straight to the result state.
// Server and resolve: the scan reads one memory entry per cycle, newest first, until a hit
// or until all ENTRIES entries are read; the word then goes to the result state.
// One word is in work at a time; a finished result may wait in the output
// register while the next word is accepted and scanned.
// Reset empties the table at once (per-entry valid flops), no clearing pass.
// Output stall only delays the move of a result into the output register.
`default_nettype none

module timed_pending_match_table #(
  parameter int ENTRIES = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [1:0]        in_mode,
  input  wire  [31:0]       in_now_ms,
  input  wire  signed [31:0] in_object_id,
  input  wire  [31:0]       in_mob_handle,
  input  wire  signed [31:0] in_amount,
  input  wire               in_critical,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [1:0]        out_outcome,
  output logic [30:0]       out_shown_amount,
  output logic              out_shown_critical,
  input  wire               cfg_wr_en,
  input  wire  [30:0]       cfg_wr_data
);
  import tpmt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  logic [1:0]         state_r, state_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]   wp_r, wp_nxt;
  logic [30:0]        hold_r;

  logic [1:0]         op_mode_r;
  logic [31:0]        now_r;
  logic [31:0]        obj_r;
  logic [31:0]        handle_r;
  logic [30:0]        amt_r;
  logic               crit_r;

  logic [IDX_W-1:0]   iss_addr_r, iss_addr_nxt;
  logic [CNT_W-1:0]   iss_left_r, iss_left_nxt;
  logic               rd_vld_r, rd_last_r;
  logic [IDX_W-1:0]   proc_addr_r;

  logic [1:0]         res_outcome_r, res_outcome_nxt;
  logic [30:0]        res_amount_r, res_amount_nxt;
  logic               res_crit_r, res_crit_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_outcome_r;
  logic [30:0]        out_amount_r;
  logic               out_crit_r;
  logic               out_load;

  logic               in_acc, add_ok, srv_ok, res_ok;
  logic               issue, expired, live, hit;
  logic [31:0]        diff;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   wp_prev;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign add_ok    = (in_mob_handle != 32'd0) && !in_amount[31] && (in_amount != 32'sd0);
  assign srv_ok    = (in_object_id != 32'sd0) && !in_amount[31];
  assign res_ok    = add_ok;
  assign wp_prev   = (wp_r == '0) ? LAST_IDX : wp_r - 1'b1;

  assign diff    = rd_data_r.expiry - now_r;
  assign expired = (diff == 32'd0) || diff[31];
  assign live    = rd_vld_r && valid_r[proc_addr_r] && !expired;

  always_comb begin
    hit = 1'b0;
    if (live) begin
      if (op_mode_r == MODE_SERVER) begin
        hit = (rd_data_r.object_id == obj_r) && !rd_data_r.flags[FLAG_READY];
      end else begin
        hit = (rd_data_r.handle == handle_r) && (rd_data_r.loc_amount == amt_r) &&
              !rd_data_r.flags[FLAG_SHOWN];
      end
    end
  end

  assign issue    = (state_r == ST_SCAN) && (iss_left_r != '0) && !hit;
  assign out_load = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    wp_nxt          = wp_r;
    iss_addr_nxt    = iss_addr_r;
    iss_left_nxt    = iss_left_r;
    res_outcome_nxt = res_outcome_r;
    res_amount_nxt  = res_amount_r;
    res_crit_nxt    = res_crit_r;
    mem_we          = 1'b0;
    mem_waddr       = proc_addr_r;
    mem_wdata       = rd_data_r;
    out_valid_nxt   = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_outcome_nxt = OUT_NONE;
          res_amount_nxt  = '0;
          res_crit_nxt    = 1'b0;
          state_nxt       = ST_RESULT;
          if (in_mode == MODE_ADD && add_ok) begin
            mem_we               = 1'b1;
            mem_waddr            = wp_r;
            mem_wdata.handle     = in_mob_handle;
            mem_wdata.object_id  = in_object_id;
            mem_wdata.loc_amount = in_amount[30:0];
            mem_wdata.expiry     = in_now_ms + {1'b0, hold_r};
            mem_wdata.srv_amount = '0;
            mem_wdata.flags      = '0;
            valid_nxt[wp_r]      = 1'b1;
            wp_nxt               = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
            res_outcome_nxt      = OUT_HIT;
          end else if ((in_mode == MODE_SERVER && srv_ok) ||
                       (in_mode == MODE_RESOLVE && res_ok)) begin
            state_nxt    = ST_SCAN;
            iss_addr_nxt = wp_prev;
            iss_left_nxt = CNT_FULL;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          iss_addr_nxt = (iss_addr_r == '0) ? LAST_IDX : iss_addr_r - 1'b1;
          iss_left_nxt = iss_left_r - 1'b1;
        end
        if (rd_vld_r && valid_r[proc_addr_r] && expired) begin
          valid_nxt[proc_addr_r] = 1'b0;
        end
        if (hit) begin
          state_nxt = ST_RESULT;
          if (op_mode_r == MODE_SERVER) begin
            res_outcome_nxt = OUT_HIT;
            if (rd_data_r.flags[FLAG_SHOWN]) begin
              valid_nxt[proc_addr_r] = 1'b0;
            end else begin
              mem_we                          = 1'b1;
              mem_wdata.srv_amount            = amt_r;
              mem_wdata.flags[FLAG_READY]     = 1'b1;
              mem_wdata.flags[FLAG_CRIT]      = crit_r;
            end
          end else if (!rd_data_r.flags[FLAG_READY]) begin
            res_outcome_nxt             = OUT_SHOWN;
            mem_we                      = 1'b1;
            mem_wdata.flags[FLAG_SHOWN] = 1'b1;
          end else begin
            res_outcome_nxt        = OUT_HIT;
            res_amount_nxt         = rd_data_r.srv_amount;
            res_crit_nxt           = rd_data_r.flags[FLAG_CRIT];
            valid_nxt[proc_addr_r] = 1'b0;
          end
        end else if (rd_vld_r && rd_last_r) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_r <= mem[iss_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      wp_r        <= '0;
      hold_r      <= HOLD_RESET;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
      iss_left_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      wp_r        <= wp_nxt;
      rd_vld_r    <= issue;
      rd_last_r   <= issue && (iss_left_r == CNT_ONE);
      out_valid_r <= out_valid_nxt;
      iss_left_r  <= iss_left_nxt;
      if (cfg_wr_en) begin
        hold_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_addr_r    <= iss_addr_nxt;
    proc_addr_r   <= iss_addr_r;
    res_outcome_r <= res_outcome_nxt;
    res_amount_r  <= res_amount_nxt;
    res_crit_r    <= res_crit_nxt;
    if (in_acc) begin
      op_mode_r <= in_mode;
      now_r     <= in_now_ms;
      obj_r     <= in_object_id;
      handle_r  <= in_mob_handle;
      amt_r     <= in_amount[30:0];
      crit_r    <= in_critical;
    end
    if (out_load) begin
      out_outcome_r <= res_outcome_r;
      out_amount_r  <= res_amount_r;
      out_crit_r    <= res_crit_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_shown_amount   = out_amount_r;
  assign out_shown_critical = out_crit_r;

endmodule

`default_nettype wire

FILE: sv/tpmt_checker.sv
// Port-level checks for the timed pending match table, bound to the top level.
// Uses tpmt_pkg (outcome codes).
`default_nettype none

module tpmt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_outcome,
  input wire [30:0] out_shown_amount,
  input wire        out_shown_critical
);
  import tpmt_pkg::*;

  a_out_hold: assert property (@(posedge clk)
    rst_n && out_valid && out_stall |=> out_valid && $stable(out_outcome) &&
      $stable(out_shown_amount) && $stable(out_shown_critical))
    else $error("stalled result word changed");

  a_value_only_on_hit: assert property (@(posedge clk)
    out_valid && out_outcome != OUT_HIT |-> out_shown_amount == 31'd0 && !out_shown_critical)
    else $error("returned value without a hit");

  a_reset_empties_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

  a_one_word_in_work: assert property (@(posedge clk)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

endmodule

bind timed_pending_match_table tpmt_checker u_tpmt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_outcome        (out_outcome),
  .out_shown_amount   (out_shown_amount),
  .out_shown_critical (out_shown_critical)
);

`default_nettype wire
